FILE: sv/cpr_pkg.sv
package cpr_pkg;

    localparam int PAGE_W         = 16;
    localparam int IDX_W          = 5;
    localparam int CFG_W          = 6;
    localparam int DEF_MAX_FRAMES = 32;

    localparam logic [CFG_W-1:0]  CFG_RESET = CFG_W'(32);
    localparam logic [PAGE_W-1:0] FAULT_MAX = '1;

    typedef struct packed {
        logic [PAGE_W-1:0] page_number;
        logic              restart;
    } cpr_in_t;

    typedef struct packed {
        logic              hit;
        logic [IDX_W-1:0]  frame_index;
        logic              evicted_valid;
        logic [PAGE_W-1:0] evicted_page;
        logic [PAGE_W-1:0] fault_total;
    } cpr_out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SWEEP,
        ST_EVICT,
        ST_FINISH
    } cpr_state_t;

endpackage

FILE: sv/cpr_page_ram.sv
module cpr_page_ram #(
    parameter int DEPTH = 32,
    parameter int AW    = 5,
    parameter int DW    = 16
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data,
    input  logic [AW-1:0] rd_addr,
    output logic [DW-1:0] rd_data
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: sv/clock_page_replacement.sv
// Clock (second-chance) page replacement over up to MAX_FRAMES frames, one
// access at a time. An access transfer names a page; the block walks the
// frames from frame 0 with a single comparator, one frame per cycle, reading
// the page store through its registered port, and the lowest active frame
// that holds the page is the hit (its use bit is set, the hand stays). On a
// miss the hand sweeps one frame per cycle, clearing set use bits, until it
// finds a clear one; that frame is read once more for the evicted page, then
// rewritten with the new page. The frame walk and the sweep both run through
// the one read port of the page store. in_stall is high from accept until the
// result is loaded into the output register; the output register holds one
// result, so a new access can be accepted while the previous result still
// waits on out_stall. active_frames (reset 32) may be written only while the
// block is idle; 0 is taken as 1 and values above MAX_FRAMES as MAX_FRAMES.
// A restart bit in an access clears all frames, use bits, the hand and the
// fault count before that access is handled.
module clock_page_replacement #(
    parameter int MAX_FRAMES = cpr_pkg::DEF_MAX_FRAMES
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wr_en,
    input  logic [cpr_pkg::CFG_W-1:0]   cfg_wr_data,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  cpr_pkg::cpr_in_t            in_data,
    output logic                        out_valid,
    input  logic                        out_stall,
    output cpr_pkg::cpr_out_t           out_data
);

    import cpr_pkg::*;

    // frame index width and active count width
    localparam int IW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int CW = $clog2(MAX_FRAMES + 1);

    cpr_state_t state_reg, state_next;

    logic [CFG_W-1:0]      active_frames_reg;
    logic [CW-1:0]         n_reg, n_next, act_count;
    logic [IW-1:0]         cmp_idx_reg, cmp_idx_next;
    logic [IW-1:0]         hand_reg, hand_next;
    logic [IW-1:0]         slot_reg, slot_next;
    logic [PAGE_W-1:0]     page_reg, page_next;
    logic [PAGE_W-1:0]     fault_reg, fault_next, fault_inc;
    logic [MAX_FRAMES-1:0] valid_reg, valid_next;
    logic [MAX_FRAMES-1:0] use_reg, use_next;
    cpr_out_t              res_reg, res_next;
    cpr_out_t              out_data_reg, out_data_next;
    logic                  out_valid_reg, out_valid_next;

    // page store port signals
    logic                  wr_en;
    logic [IW-1:0]         rd_addr;
    logic [PAGE_W-1:0]     rd_data;

    logic                  in_fire;
    logic                  match;
    logic                  scan_end;
    logic                  last_idx;

    // hand step, wrapping at the active count
    function automatic logic [IW-1:0] wrap_inc(input logic [IW-1:0] idx,
                                               input logic [CW-1:0] cnt);
        logic [CW-1:0] s;
        s = CW'(idx) + CW'(1);
        if (s == cnt)
        begin
            return '0;
        end
        return IW'(s);
    endfunction

    cpr_page_ram #(
        .DEPTH (MAX_FRAMES),
        .AW    (IW),
        .DW    (PAGE_W)
    ) u_page_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (slot_reg),
        .wr_data (page_reg),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_frames_reg <= CFG_RESET;
        end
        else if (cfg_wr_en)
        begin
            active_frames_reg <= cfg_wr_data;
        end
    end

    // active count: zero means one, clamp at the frame count
    always_comb
    begin
        if (active_frames_reg == '0)
        begin
            act_count = CW'(1);
        end
        else if (int'(active_frames_reg) > MAX_FRAMES)
        begin
            act_count = CW'(MAX_FRAMES);
        end
        else
        begin
            act_count = CW'(active_frames_reg);
        end
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_fire   = in_valid && !in_stall;
    assign match     = valid_reg[cmp_idx_reg] && (rd_data == page_reg);
    assign scan_end  = ((CW'(cmp_idx_reg) + CW'(1)) == n_reg);
    assign last_idx  = (cmp_idx_reg == IW'(MAX_FRAMES - 1));
    assign fault_inc = (fault_reg == FAULT_MAX) ? fault_reg : fault_reg + PAGE_W'(1);

    // sequencer: next state and datapath updates
    always_comb
    begin
        state_next     = state_reg;
        n_next         = n_reg;
        cmp_idx_next   = cmp_idx_reg;
        hand_next      = hand_reg;
        slot_next      = slot_reg;
        page_next      = page_reg;
        fault_next     = fault_reg;
        valid_next     = valid_reg;
        use_next       = use_reg;
        res_next       = res_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg;
        wr_en          = 1'b0;
        rd_addr        = cmp_idx_reg;

        // result taken downstream
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                // prime the store read for frame 0
                rd_addr = '0;
                if (in_fire)
                begin
                    page_next    = in_data.page_number;
                    n_next       = act_count;
                    cmp_idx_next = '0;
                    if (in_data.restart)
                    begin
                        valid_next = '0;
                        use_next   = '0;
                        hand_next  = '0;
                        fault_next = '0;
                    end
                    state_next = ST_SCAN;
                end
            end

            ST_SCAN:
            begin
                // read ahead one frame while comparing the current one
                rd_addr = last_idx ? '0 : cmp_idx_reg + IW'(1);
                if (match)
                begin
                    use_next[cmp_idx_reg]  = 1'b1;
                    res_next.hit           = 1'b1;
                    res_next.frame_index   = IDX_W'(cmp_idx_reg);
                    res_next.evicted_valid = 1'b0;
                    res_next.evicted_page  = '0;
                    res_next.fault_total   = fault_reg;
                    state_next             = ST_FINISH;
                end
                else if (scan_end)
                begin
                    // hand left behind by a shrunk count restarts at frame 0
                    if (CW'(hand_reg) >= n_reg)
                    begin
                        hand_next = '0;
                    end
                    state_next = ST_SWEEP;
                end
                else
                begin
                    cmp_idx_next = cmp_idx_reg + IW'(1);
                end
            end

            ST_SWEEP:
            begin
                rd_addr = hand_reg;
                if (use_reg[hand_reg])
                begin
                    // second chance
                    use_next[hand_reg] = 1'b0;
                    hand_next          = wrap_inc(hand_reg, n_reg);
                end
                else
                begin
                    slot_next  = hand_reg;
                    state_next = ST_EVICT;
                end
            end

            ST_EVICT:
            begin
                // rd_data holds the victim frame's page
                rd_addr                = slot_reg;
                wr_en                  = 1'b1;
                valid_next[slot_reg]   = 1'b1;
                use_next[slot_reg]     = 1'b1;
                hand_next              = wrap_inc(slot_reg, n_reg);
                fault_next             = fault_inc;
                res_next.hit           = 1'b0;
                res_next.frame_index   = IDX_W'(slot_reg);
                res_next.evicted_valid = valid_reg[slot_reg];
                res_next.evicted_page  = valid_reg[slot_reg] ? rd_data : '0;
                res_next.fault_total   = fault_inc;
                state_next             = ST_FINISH;
            end

            ST_FINISH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = res_reg;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_reg         <= CW'(1);
            cmp_idx_reg   <= '0;
            hand_reg      <= '0;
            fault_reg     <= '0;
            valid_reg     <= '0;
            use_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            n_reg         <= n_next;
            cmp_idx_reg   <= cmp_idx_next;
            hand_reg      <= hand_next;
            fault_reg     <= fault_next;
            valid_reg     <= valid_next;
            use_reg       <= use_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        slot_reg     <= slot_next;
        page_reg     <= page_next;
        res_reg      <= res_next;
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule
